// ===== hw/rtl/gfp_pkg.sv =====
// Shared types, codes and sizes for the gshare fetch predictor.
package gfp_pkg;

    // Address space of the instruction store, settled by the address field widths
    localparam int ADDR_BITS  = 10;
    localparam int ADDR_DEPTH = 2 ** ADDR_BITS;
    localparam int PC_W       = ADDR_BITS + 1;

    // Defaults for the top-level parameters
    localparam int DEF_FETCH_SLOTS  = 4;
    localparam int DEF_HISTORY_BITS = 10;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int KIND_W    = 2;
    localparam int AMOUNT_W  = 3;
    localparam int COUNT_W   = 3;
    localparam int CTR_W     = 2;

    // PC limits
    localparam logic [PC_W-1:0] PC_MAX    = '1;
    localparam logic [PC_W-1:0] LEN_LIMIT = PC_W'(ADDR_DEPTH);

    // Commands
    localparam logic [CMD_W-1:0] CMD_FETCH     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESOLVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_BTB = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_PC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_KIND = 3'd5;

    // Instruction kinds
    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNCOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COND   = 2'd2;

    // Two-bit counter values
    localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;

    // Pattern table entry
    typedef struct packed {
        logic             valid;
        logic [CTR_W-1:0] ctr;
    } t_pht_entry;

    // Branch target buffer entry
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] target;
    } t_btb_entry;

endpackage

// ===== hw/rtl/gfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gfp_ctr_unit.sv =====
// Shared two-bit counter unit: prediction on fetch, training on resolve.
module gfp_ctr_unit (
    input  gfp_pkg::t_pht_entry i_entry,
    input  logic                i_resolve,
    input  logic                i_outcome,
    output logic                o_taken,
    output gfp_pkg::t_pht_entry o_entry
);

    import gfp_pkg::*;

    logic [CTR_W-1:0] ctr_eff;
    logic [CTR_W-1:0] ctr_new;

    // Untouched entry: weakly taken on predict, zero on resolve
    always_comb begin
        if (i_entry.valid) begin
            ctr_eff = i_entry.ctr;
        end else if (i_resolve) begin
            ctr_eff = CTR_MIN;
        end else begin
            ctr_eff = CTR_WEAK_TAKEN;
        end
    end

    // Saturating step on resolve, hold on predict
    always_comb begin
        ctr_new = ctr_eff;
        if (i_resolve) begin
            if (i_outcome) begin
                if (ctr_eff != CTR_MAX) begin
                    ctr_new = ctr_eff + 1'b1;
                end
            end else if (ctr_eff != CTR_MIN) begin
                ctr_new = ctr_eff - 1'b1;
            end
        end
    end

    assign o_taken       = (ctr_eff >= CTR_WEAK_TAKEN);
    assign o_entry.valid = 1'b1;
    assign o_entry.ctr   = ctr_new;

endmodule

// ===== hw/rtl/gshare_fetch_predictor.sv =====
// Fetch front end with gshare predictor, BTB and instruction-kind store.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready + command fields  | into block
//  out     | o_out_valid / i_out_ready + result fields | out of block
//  cfg     | i_cfg_valid / o_cfg_ready + i_cfg_data    | into block
//
//  Fetch scans N slots, N = 0..FETCH_SLOTS, and then finishes: the scan reads the
//  kind, BTB and pattern RAMs at one address per cycle. Resolve reads the pattern
//  RAM, then updates the counter; other commands go straight to finish.
//  After reset a pass over all 2**max(HISTORY_BITS, ADDR_BITS) pattern table entries
//  (1024 by default) clears them and the BTB valid bits; input is held off then.
//  A new item is taken while the previous result waits on the output register;
//  a finished result waits in place until the output register frees up.
module gshare_fetch_predictor #(
    parameter int FETCH_SLOTS  = gfp_pkg::DEF_FETCH_SLOTS,
    parameter int HISTORY_BITS = gfp_pkg::DEF_HISTORY_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [gfp_pkg::CMD_W-1:0]           i_command,
    input  logic [gfp_pkg::ADDR_BITS-1:0]       i_branch_address,
    input  logic [gfp_pkg::ADDR_BITS-1:0]       i_dest_address,
    input  logic                                i_taken,
    input  logic [gfp_pkg::AMOUNT_W-1:0]        i_advance_amount,
    input  logic [gfp_pkg::KIND_W-1:0]          i_instruction_kind,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gfp_pkg::PC_W-1:0]            o_program_counter,
    output logic                                o_fetch_is_set,
    output logic [gfp_pkg::PC_W-1:0]            o_group_start,
    output logic [gfp_pkg::COUNT_W-1:0]         o_slot_count,
    output logic                                o_redirected,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gfp_pkg::PC_W-1:0]            i_cfg_data
);

    import gfp_pkg::*;

    localparam int PHT_BITS  = (HISTORY_BITS > ADDR_BITS) ? HISTORY_BITS : ADDR_BITS;
    localparam int PHT_DEPTH = 2 ** PHT_BITS;
    localparam int CNT_W     = $clog2(FETCH_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_FINISH
    } t_state;

    t_state                  r_state, n_state;
    logic [PHT_BITS-1:0]     r_clr, n_clr;
    logic [PC_W-1:0]         r_len, n_len;
    logic [PC_W-1:0]         r_pc, n_pc;
    logic                    r_set, n_set;
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [PC_W-1:0]         r_addr, n_addr;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [PC_W-1:0]         r_start, n_start;
    logic                    r_redir, n_redir;
    logic                    r_taken, n_taken;
    logic [ADDR_BITS-1:0]    r_rbaddr, n_rbaddr;
    logic                    r_out_valid, n_out_valid;
    logic [PC_W-1:0]         r_o_pc, n_o_pc;
    logic                    r_o_set, n_o_set;
    logic [PC_W-1:0]         r_o_start, n_o_start;
    logic [COUNT_W-1:0]      r_o_count, n_o_count;
    logic                    r_o_redir, n_o_redir;

    // RAM ports
    logic                    pht_we;
    logic [PHT_BITS-1:0]     pht_waddr, pht_raddr;
    t_pht_entry              pht_wdata, pht_rdata;
    logic                    btb_we;
    logic [ADDR_BITS-1:0]    btb_waddr;
    t_btb_entry              btb_wdata, btb_rdata;
    logic                    kind_we;
    logic [KIND_W-1:0]       kind_rdata;

    // Counter unit
    logic                    unit_taken;
    t_pht_entry              unit_entry;

    // Scan helpers
    logic [PC_W-1:0]         eff_len;
    logic [PHT_BITS-1:0]     hist_ext;
    logic [PHT_BITS-1:0]     scan_idx;
    logic [PHT_BITS-1:0]     resolve_idx;
    logic [PC_W-1:0]         addr_inc;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    is_branch;
    logic                    take;
    logic                    last_slot;
    logic [PC_W:0]           adv_sum;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;
    logic [HISTORY_BITS:0]   hist_shift;

    gfp_ram #(
        .WIDTH ($bits(t_pht_entry)),
        .DEPTH (PHT_DEPTH)
    ) u_pht (
        .i_clk   (i_clk),
        .i_we    (pht_we),
        .i_waddr (pht_waddr),
        .i_wdata (pht_wdata),
        .i_raddr (pht_raddr),
        .o_rdata (pht_rdata)
    );

    gfp_ram #(
        .WIDTH ($bits(t_btb_entry)),
        .DEPTH (ADDR_DEPTH)
    ) u_btb (
        .i_clk   (i_clk),
        .i_we    (btb_we),
        .i_waddr (btb_waddr),
        .i_wdata (btb_wdata),
        .i_raddr (n_addr[ADDR_BITS-1:0]),
        .o_rdata (btb_rdata)
    );

    gfp_ram #(
        .WIDTH (KIND_W),
        .DEPTH (ADDR_DEPTH)
    ) u_kind (
        .i_clk   (i_clk),
        .i_we    (kind_we),
        .i_waddr (i_branch_address),
        .i_wdata (i_instruction_kind),
        .i_raddr (n_addr[ADDR_BITS-1:0]),
        .o_rdata (kind_rdata)
    );

    gfp_ctr_unit u_ctr (
        .i_entry   (pht_rdata),
        .i_resolve (r_state == ST_RESOLVE),
        .i_outcome (r_taken),
        .o_taken   (unit_taken),
        .o_entry   (unit_entry)
    );

    // Scan address, slot and branch decisions
    assign eff_len     = (r_len > LEN_LIMIT) ? LEN_LIMIT : r_len;
    assign hist_ext    = PHT_BITS'(r_hist);
    assign scan_idx    = hist_ext ^ PHT_BITS'(r_addr[ADDR_BITS-1:0]);
    assign resolve_idx = hist_ext ^ PHT_BITS'(r_rbaddr);
    assign addr_inc    = r_addr + 1'b1;
    assign cnt_inc     = r_cnt + 1'b1;
    assign is_branch   = ((kind_rdata == KIND_UNCOND) || (kind_rdata == KIND_COND))
                         && btb_rdata.valid;
    assign take        = is_branch && ((kind_rdata == KIND_UNCOND) || unit_taken);
    assign last_slot   = (cnt_inc == CNT_W'(FETCH_SLOTS)) || (addr_inc >= eff_len);
    assign adv_sum     = {1'b0, r_pc} + (PC_W + 1)'(i_advance_amount);
    assign cnt_wide    = {{COUNT_W{1'b0}}, r_cnt};
    assign hist_shift  = {r_hist, r_taken};

    // Pattern table read: resolve address on accept, else the next scan address
    always_comb begin
        if ((r_state == ST_IDLE) && (i_command == CMD_RESOLVE)) begin
            pht_raddr = hist_ext ^ PHT_BITS'(i_branch_address);
        end else begin
            pht_raddr = hist_ext ^ PHT_BITS'(n_addr[ADDR_BITS-1:0]);
        end
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_len       = i_cfg_valid ? i_cfg_data : r_len;
        n_pc        = r_pc;
        n_set       = r_set;
        n_hist      = r_hist;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_start     = r_start;
        n_redir     = r_redir;
        n_taken     = r_taken;
        n_rbaddr    = r_rbaddr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_pc      = r_o_pc;
        n_o_set     = r_o_set;
        n_o_start   = r_o_start;
        n_o_count   = r_o_count;
        n_o_redir   = r_o_redir;
        pht_we      = 1'b0;
        pht_waddr   = scan_idx;
        pht_wdata   = unit_entry;
        btb_we      = 1'b0;
        btb_waddr   = i_branch_address;
        btb_wdata   = '{valid: 1'b1, target: i_dest_address};
        kind_we     = 1'b0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // Sweep pattern table and BTB valid bits
                pht_we    = 1'b1;
                pht_waddr = r_clr;
                pht_wdata = '0;
                btb_we    = 1'b1;
                btb_waddr = r_clr[ADDR_BITS-1:0];
                btb_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == {PHT_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_addr     = r_pc;
                if (i_in_valid) begin
                    n_start = '0;
                    n_cnt   = '0;
                    n_redir = 1'b0;
                    n_state = ST_FINISH;
                    unique case (i_command)
                        CMD_FETCH: begin
                            if (r_pc < eff_len) begin
                                n_set   = 1'b0;
                                n_start = r_pc;
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_RESOLVE: begin
                            n_taken  = i_taken;
                            n_rbaddr = i_branch_address;
                            n_state  = ST_RESOLVE;
                        end
                        CMD_WRITE_BTB: begin
                            btb_we = 1'b1;
                        end
                        CMD_SET_PC: begin
                            n_pc  = PC_W'(i_dest_address);
                            n_set = 1'b1;
                        end
                        CMD_ADVANCE: begin
                            n_pc = (adv_sum > {1'b0, PC_MAX}) ? PC_MAX : adv_sum[PC_W-1:0];
                        end
                        CMD_LOAD_KIND: begin
                            kind_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // One slot per cycle; mark an untouched counter weakly taken
                n_cnt = cnt_inc;
                if ((kind_rdata == KIND_COND) && btb_rdata.valid && !pht_rdata.valid) begin
                    pht_we = 1'b1;
                end
                if (take) begin
                    n_pc    = PC_W'(btb_rdata.target);
                    n_set   = 1'b1;
                    n_redir = 1'b1;
                    n_state = ST_FINISH;
                end else if (last_slot) begin
                    n_state = ST_FINISH;
                end else begin
                    n_addr = addr_inc;
                end
            end
            ST_RESOLVE: begin
                // Train the counter and shift the outcome into history
                pht_we    = 1'b1;
                pht_waddr = resolve_idx;
                n_hist    = hist_shift[HISTORY_BITS-1:0];
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_pc      = r_pc;
                    n_o_set     = r_set;
                    n_o_start   = r_start;
                    n_o_count   = cnt_wide[COUNT_W-1:0];
                    n_o_redir   = r_redir;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_len       <= '0;
            r_pc        <= '0;
            r_set       <= 1'b0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_len       <= n_len;
            r_pc        <= n_pc;
            r_set       <= n_set;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_start     <= n_start;
            r_redir     <= n_redir;
            r_taken     <= n_taken;
            r_rbaddr    <= n_rbaddr;
            r_o_pc      <= n_o_pc;
            r_o_set     <= n_o_set;
            r_o_start   <= n_o_start;
            r_o_count   <= n_o_count;
            r_o_redir   <= n_o_redir;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_o_pc;
    assign o_fetch_is_set    = r_o_set;
    assign o_group_start     = r_o_start;
    assign o_slot_count      = r_o_count;
    assign o_redirected      = r_o_redir;

endmodule

// ===== hw/rtl/gfp_checker.sv =====
// Port-level checks for the gshare fetch predictor, bound to the top level.
module gfp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [gfp_pkg::PC_W-1:0]      o_program_counter,
    input logic                          o_fetch_is_set,
    input logic [gfp_pkg::PC_W-1:0]      o_group_start,
    input logic [gfp_pkg::COUNT_W-1:0]   o_slot_count,
    input logic                          o_redirected
);

    // Clearing pass holds off input right after reset
    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // One item at a time: busy in the cycle after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_program_counter)
            && $stable(o_group_start) && $stable(o_slot_count) && $stable(o_redirected)))
        else $error("stalled result changed");

    // Redirect sets the fetch flag and lands inside the address space
    a_redirect_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_redirected) |->
            (o_fetch_is_set && !o_program_counter[gfp_pkg::PC_W-1]))
        else $error("redirect without flag or target out of range");

endmodule

bind gshare_fetch_predictor gfp_checker u_gfp_checker (.*);

// ===== test/gshare_fetch_predictor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the gshare fetch predictor: directed cases, then random traffic.
module gshare_fetch_predictor_tb;
    import gfp_pkg::*;

    localparam int FETCH_SLOTS = DEF_FETCH_SLOTS;
    localparam int HIST_BITS   = DEF_HISTORY_BITS;

    // Commands the block treats as no-ops, and the kind code that reads as other
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

    // Pattern entry trained by the counter test
    localparam logic [ADDR_BITS-1:0] TRAIN_INDEX = 10'h155;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ADDR_BITS-1:0] branch_address;
        logic [ADDR_BITS-1:0] dest_address;
        logic                 taken;
        logic [AMOUNT_W-1:0]  advance_amount;
        logic [KIND_W-1:0]    kind;
    } t_fetch_cmd;

    typedef struct packed {
        logic [PC_W-1:0]    program_counter;
        logic               fetch_is_set;
        logic [PC_W-1:0]    group_start;
        logic [COUNT_W-1:0] slot_count;
        logic               redirected;
    } t_fetch_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command;
    logic [ADDR_BITS-1:0]  i_branch_address;
    logic [ADDR_BITS-1:0]  i_dest_address;
    logic                  i_taken;
    logic [AMOUNT_W-1:0]   i_advance_amount;
    logic [KIND_W-1:0]     i_instruction_kind;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PC_W-1:0]       o_program_counter;
    logic                  o_fetch_is_set;
    logic [PC_W-1:0]       o_group_start;
    logic [COUNT_W-1:0]    o_slot_count;
    logic                  o_redirected;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [PC_W-1:0]       i_cfg_data;

    // Predicted front-end state
    logic [PC_W-1:0]       prog_len_q;
    logic [PC_W-1:0]       pc_q;
    logic                  fetch_set_q;
    logic [HIST_BITS-1:0]  history_q;
    logic [CTR_W-1:0]      pht_ctr_q    [ADDR_DEPTH];
    logic                  pht_valid_q  [ADDR_DEPTH];
    logic [ADDR_BITS-1:0]  btb_target_q [ADDR_DEPTH];
    logic                  btb_valid_q  [ADDR_DEPTH];
    logic [KIND_W-1:0]     kind_q       [ADDR_DEPTH];
    logic                  kind_known_q [ADDR_DEPTH];

    t_fetch_result         expected_results_q[$];

    int error_count     = 0;
    int results_checked = 0;
    int redirect_count  = 0;
    int commands_sent   = 0;
    int lengths_used    = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_request   = 0;
    int stall_left      = 0;

    gshare_fetch_predictor u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_branch_address   (i_branch_address),
        .i_dest_address     (i_dest_address),
        .i_taken            (i_taken),
        .i_advance_amount   (i_advance_amount),
        .i_instruction_kind (i_instruction_kind),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_program_counter  (o_program_counter),
        .o_fetch_is_set     (o_fetch_is_set),
        .o_group_start      (o_group_start),
        .o_slot_count       (o_slot_count),
        .o_redirected       (o_redirected),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("Timeout: %0d results still outstanding", expected_results_q.size());
        $display("TB_ERROR");
        $finish;
    end

    // Length limited to the address space
    function automatic int effective_length();
        return (prog_len_q > LEN_LIMIT) ? int'(LEN_LIMIT) : int'(prog_len_q);
    endfunction

    // Advance the predicted state by one command and return its result
    function automatic t_fetch_result predict_result(t_fetch_cmd c);
        t_fetch_result          r;
        int                     len;
        int                     a;
        int                     sum;
        logic [KIND_W-1:0]      k;
        logic [ADDR_BITS-1:0]   idx;
        logic [CTR_W-1:0]       ctr;
        logic                   go;
        r = '0;
        case (c.command)
            CMD_FETCH: begin
                len = effective_length();
                if (int'(pc_q) < len) begin
                    r.group_start = pc_q;
                    fetch_set_q   = 1'b0;
                    a             = int'(pc_q);
                    // Scan slots until the group is full, the program ends or a branch redirects
                    while (r.slot_count < FETCH_SLOTS && a < len && !r.redirected) begin
                        k            = kind_q[a];
                        r.slot_count = r.slot_count + 1'b1;
                        if ((k == KIND_UNCOND || k == KIND_COND) && btb_valid_q[a]) begin
                            go = 1'b1;
                            if (k == KIND_COND) begin
                                idx = ADDR_BITS'(history_q) ^ a[ADDR_BITS-1:0];
                                // Untouched entry reads as weakly taken and is kept that way
                                if (!pht_valid_q[idx]) begin
                                    pht_valid_q[idx] = 1'b1;
                                    pht_ctr_q[idx]   = CTR_WEAK_TAKEN;
                                end
                                go = (pht_ctr_q[idx] >= CTR_WEAK_TAKEN);
                            end
                            if (go) begin
                                pc_q         = {1'b0, btb_target_q[a]};
                                fetch_set_q  = 1'b1;
                                r.redirected = 1'b1;
                            end
                        end
                        a++;
                    end
                end
            end
            CMD_RESOLVE: begin
                idx = ADDR_BITS'(history_q) ^ c.branch_address;
                // Untouched entry trains from zero
                ctr = pht_valid_q[idx] ? pht_ctr_q[idx] : CTR_MIN;
                if (c.taken) begin
                    if (ctr != CTR_MAX) ctr = ctr + 1'b1;
                end else if (ctr != CTR_MIN) begin
                    ctr = ctr - 1'b1;
                end
                pht_ctr_q[idx]   = ctr;
                pht_valid_q[idx] = 1'b1;
                history_q        = {history_q[HIST_BITS-2:0], c.taken};
            end
            CMD_WRITE_BTB: begin
                btb_target_q[c.branch_address] = c.dest_address;
                btb_valid_q[c.branch_address]  = 1'b1;
            end
            CMD_SET_PC: begin
                pc_q        = {1'b0, c.dest_address};
                fetch_set_q = 1'b1;
            end
            CMD_ADVANCE: begin
                sum  = int'(pc_q) + int'(c.advance_amount);
                pc_q = (sum > int'(PC_MAX)) ? PC_MAX : PC_W'(sum);
            end
            CMD_LOAD_KIND: begin
                kind_q[c.branch_address]       = c.kind;
                kind_known_q[c.branch_address] = 1'b1;
            end
            default: begin
            end
        endcase
        r.program_counter = pc_q;
        r.fetch_is_set    = fetch_set_q;
        return r;
    endfunction

    // Build a command with random content in every field
    function automatic t_fetch_cmd random_cmd(logic [CMD_W-1:0] cmd);
        t_fetch_cmd c;
        c.command        = cmd;
        c.branch_address = ADDR_BITS'($urandom);
        c.dest_address   = ADDR_BITS'($urandom);
        c.taken          = 1'($urandom);
        c.advance_amount = AMOUNT_W'($urandom);
        c.kind           = KIND_W'($urandom);
        return c;
    endfunction

    // Address in a 32-entry window most of the time, anywhere otherwise
    function automatic logic [ADDR_BITS-1:0] near_address(int base);
        if ($urandom_range(9) == 0) return ADDR_BITS'($urandom);
        return ADDR_BITS'(base + $urandom_range(31));
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", results_checked, msg);
        error_count++;
    endtask

    // Offer one command; keep valid high after the transfer so back-to-back items stay put
    task automatic send_item(t_fetch_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_command          <= c.command;
        i_branch_address   <= c.branch_address;
        i_dest_address     <= c.dest_address;
        i_taken            <= c.taken;
        i_advance_amount   <= c.advance_amount;
        i_instruction_kind <= c.kind;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results_q.push_back(predict_result(c));
        commands_sent++;
    endtask

    task automatic send_fields(logic [CMD_W-1:0] cmd, logic [ADDR_BITS-1:0] baddr,
                               logic [ADDR_BITS-1:0] taddr, logic taken,
                               logic [KIND_W-1:0] kind);
        t_fetch_cmd c;
        c                = random_cmd(cmd);
        c.branch_address = baddr;
        c.dest_address   = taddr;
        c.taken          = taken;
        c.kind           = kind;
        send_item(c);
    endtask

    // Fetch, first loading a kind into any slot the scan may read that was never written
    task automatic issue_fetch();
        int a;
        for (a = int'(pc_q); a < int'(pc_q) + FETCH_SLOTS && a < effective_length(); a++) begin
            if (!kind_known_q[a])
                send_fields(CMD_LOAD_KIND, ADDR_BITS'(a), ADDR_BITS'($urandom), 1'($urandom),
                            KIND_W'($urandom));
        end
        send_item(random_cmd(CMD_FETCH));
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_program_length(logic [PC_W-1:0] len);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prog_len_q  = len;
        lengths_used++;
    endtask

    task automatic send_random_item(int base);
        t_fetch_cmd c;
        int         r;
        r = $urandom_range(99);
        if (r < 35) begin
            issue_fetch();
        end else begin
            if (r < 50) begin
                c                = random_cmd(CMD_RESOLVE);
                c.branch_address = near_address(base);
            end else if (r < 63) begin
                c                = random_cmd(CMD_WRITE_BTB);
                c.branch_address = near_address(base);
                c.dest_address   = near_address(base);
            end else if (r < 75) begin
                c = random_cmd(CMD_SET_PC);
                // Occasionally land on the top of the address space
                if ($urandom_range(19) == 0)
                    c.dest_address = ADDR_BITS'(ADDR_DEPTH - 1 - $urandom_range(3));
                else
                    c.dest_address = near_address(base);
            end else if (r < 83) begin
                c = random_cmd(CMD_ADVANCE);
            end else if (r < 95) begin
                c                = random_cmd(CMD_LOAD_KIND);
                c.branch_address = near_address(base);
                if ($urandom_range(3) != 0)
                    c.kind = $urandom_range(1) ? KIND_UNCOND : KIND_COND;
            end else begin
                c = random_cmd($urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO);
            end
            send_item(c);
        end
    endtask

    // Zero length: fetch yields nothing and leaves the set flag alone; spare commands
    task automatic test_empty_program();
        write_program_length('0);
        issue_fetch();
        send_fields(CMD_SET_PC, '0, 10'd5, 1'b0, KIND_OTHER);
        issue_fetch();
        send_item(random_cmd(CMD_SPARE_LO));
        send_item(random_cmd(CMD_SPARE_HI));
        wait_drain();
    endtask

    // Conditional and unconditional redirects, spare kind code, end of program
    task automatic test_fetch_redirect();
        write_program_length(11'd16);
        send_fields(CMD_LOAD_KIND, 10'd0, '0, 1'b0, KIND_OTHER);
        send_fields(CMD_LOAD_KIND, 10'd1, '0, 1'b0, KIND_SPARE);
        send_fields(CMD_LOAD_KIND, 10'd2, '0, 1'b0, KIND_COND);
        send_fields(CMD_LOAD_KIND, 10'd3, '0, 1'b0, KIND_UNCOND);
        send_fields(CMD_WRITE_BTB, 10'd1, 10'd9, 1'b0, KIND_OTHER);
        send_fields(CMD_WRITE_BTB, 10'd2, 10'd12, 1'b0, KIND_OTHER);
        send_fields(CMD_WRITE_BTB, 10'd3, 10'd14, 1'b0, KIND_OTHER);
        send_fields(CMD_SET_PC, '0, 10'd0, 1'b0, KIND_OTHER);
        issue_fetch();
        issue_fetch();
        send_fields(CMD_SET_PC, '0, 10'd3, 1'b0, KIND_OTHER);
        issue_fetch();
        wait_drain();
    endtask

    // Train one pattern entry up to saturation and back down to zero
    task automatic test_counter_training();
        int i;
        for (i = 0; i < 8; i++)
            send_fields(CMD_RESOLVE, ADDR_BITS'(history_q) ^ TRAIN_INDEX, '0, i < 4, KIND_OTHER);
        wait_drain();
    endtask

    // Advance from the top of the address space until the PC saturates
    task automatic test_pc_saturation();
        t_fetch_cmd c;
        send_fields(CMD_SET_PC, '0, '1, 1'b0, KIND_OTHER);
        while (pc_q != PC_MAX) begin
            c                = random_cmd(CMD_ADVANCE);
            c.advance_amount = '1;
            send_item(c);
        end
        c                = random_cmd(CMD_ADVANCE);
        c.advance_amount = '1;
        send_item(c);
        c.advance_amount = '0;
        send_item(c);
        wait_drain();
    endtask

    // Hold the result side off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        stall_request = 150;
        @(posedge i_clk);
        repeat (24) send_random_item(0);
        wait_drain();
    endtask

    task automatic run_random_phase(int count, int send_pct, int recv_pct,
                                    logic [PC_W-1:0] len);
        int base;
        write_program_length(len);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        base = (effective_length() > 40) ? $urandom_range(effective_length() - 40) : 0;
        repeat (count) begin
            if ($urandom_range(19) == 0 && effective_length() > 40)
                base = $urandom_range(effective_length() - 40);
            send_random_item(base);
        end
        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    // Drive the result-side ready: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_fetch_result exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results_q.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                exp = expected_results_q.pop_front();
                if (o_program_counter !== exp.program_counter)
                    report_mismatch($sformatf("program_counter %0d, expected %0d",
                                              o_program_counter, exp.program_counter));
                if (o_fetch_is_set !== exp.fetch_is_set)
                    report_mismatch($sformatf("fetch_is_set %0b, expected %0b",
                                              o_fetch_is_set, exp.fetch_is_set));
                if (o_group_start !== exp.group_start)
                    report_mismatch($sformatf("group_start %0d, expected %0d",
                                              o_group_start, exp.group_start));
                if (o_slot_count !== exp.slot_count)
                    report_mismatch($sformatf("slot_count %0d, expected %0d",
                                              o_slot_count, exp.slot_count));
                if (o_redirected !== exp.redirected)
                    report_mismatch($sformatf("redirected %0b, expected %0b",
                                              o_redirected, exp.redirected));
            end
            if (o_redirected === 1'b1) redirect_count++;
            results_checked++;
        end
    end

    initial begin : main_sequence
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_command          = CMD_FETCH;
        i_branch_address   = '0;
        i_dest_address     = '0;
        i_taken            = 1'b0;
        i_advance_amount   = '0;
        i_instruction_kind = KIND_OTHER;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        prog_len_q         = '0;
        pc_q               = '0;
        fetch_set_q        = 1'b0;
        history_q          = '0;
        foreach (pht_ctr_q[i]) begin
            pht_ctr_q[i]    = CTR_MIN;
            pht_valid_q[i]  = 1'b0;
            btb_target_q[i] = '0;
            btb_valid_q[i]  = 1'b0;
            kind_q[i]       = KIND_OTHER;
            kind_known_q[i] = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_program();
        test_fetch_redirect();
        test_counter_training();
        test_pc_saturation();
        test_output_backpressure();
        run_random_phase(45, 32, 66, LEN_LIMIT);
        run_random_phase(45, 66, 32, PC_MAX);
        run_random_phase(45, 0, 0, PC_W'($urandom_range(24, 300)));

        wait_drain();
        repeat (20) @(posedge i_clk);

        $display("Summary: %0d commands, %0d results checked, %0d redirects, %0d lengths",
                 commands_sent, results_checked, redirect_count, lengths_used);
        $display("Covered empty and oversize programs, counter training, PC saturation, "
                 , "a long output stall and three idle mixes; %0d mismatches", error_count);
        if (error_count == 0 && expected_results_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
